@@ rtl/core/sbba_pkg.sv @@
// Shared constants and types of the striped block bitmap allocator.
package sbba_pkg;

  // Field and register widths.
  localparam int ACTION_W = 2;
  localparam int BLOCK_W  = 10;
  localparam int STATUS_W = 2;
  localparam int DISK_W   = 3;
  localparam int MODE_W   = 2;
  localparam int DCOUNT_W = 4;
  localparam int BCOUNT_W = 11;

  localparam int DEF_MAX_BLOCKS = 1024;
  localparam int MAX_DISKS      = 8;
  localparam int MIN_DISKS      = 2;

  // Actions; any other code behaves as a test.
  localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TEST  = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTUSED = 2'd2;

  localparam logic [MODE_W-1:0] RAID_STRIPED = 2'd0;

  // Configuration register indexes.
  localparam logic [1:0] REG_MODE        = 2'd0;
  localparam logic [1:0] REG_NUM_DISKS   = 2'd1;
  localparam logic [1:0] REG_BLOCK_COUNT = 2'd2;

  localparam logic [MODE_W-1:0]   RESET_MODE        = 2'd0;
  localparam logic [DCOUNT_W-1:0] RESET_NUM_DISKS   = 4'd2;
  localparam logic [BCOUNT_W-1:0] RESET_BLOCK_COUNT = 11'd1024;

  // Control part of the request token that walks down the cell chain.
  typedef struct packed {
    logic                valid;
    logic [ACTION_W-1:0] action;
    logic                in_map;
    logic                done;
    logic                used;
  } tok_ctl_t;

endpackage

@@ rtl/core/striped_block_bitmap_allocator_top.sv @@
// Top level of the striped block bitmap allocator: config port, cell chain, divider, output.
// A request passes the register of every chain cell (ceil(MAX_BLOCKS/WORD_W) cells), then the
// divider, then the result register, which waits while the result stream is held by back-pressure.
// Requests are taken one at a time; a new one only after the last result is loaded for output.
// Reset clears the whole used map at once and loads the register defaults.
module striped_block_bitmap_allocator_top #(
  parameter int MAX_BLOCKS = sbba_pkg::DEF_MAX_BLOCKS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [9:0] block number, rest zero
  input  logic [1:0]  s_axis_tuser,  // [1:0] action
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [9:0] result_block, [10] is_allocated,
                                     // [13:11] disk_number, [23:14] disk_local_block
  output logic [1:0]  m_axis_tuser   // [1:0] status
);

  localparam int WORD_W = (MAX_BLOCKS >= 32) ? 32 : 8;
  localparam int WSEL_W = $clog2(WORD_W);
  localparam int NCELLS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int IDX_W  = ($clog2(MAX_BLOCKS) > sbba_pkg::BLOCK_W) ?
                          $clog2(MAX_BLOCKS) : sbba_pkg::BLOCK_W;
  localparam int LIM_W  = $clog2(MAX_BLOCKS + 1);
  localparam int CMP_W  = (LIM_W > sbba_pkg::BCOUNT_W) ? LIM_W : sbba_pkg::BCOUNT_W;
  localparam int DISK_SEL_W = sbba_pkg::DISK_W;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHAIN = 3'b010,
    S_DIV   = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [sbba_pkg::MODE_W-1:0]   mode_q;
  logic [sbba_pkg::DCOUNT_W-1:0] num_disks_q;
  logic [sbba_pkg::BCOUNT_W-1:0] block_count_q;
  logic                          cfg_wr;

  logic [sbba_pkg::DCOUNT_W-1:0] eff_disks;
  logic [CMP_W-1:0]              bc_ext;
  logic [LIM_W-1:0]              limit;

  sbba_pkg::tok_ctl_t chain_ctl [NCELLS+1];
  logic [IDX_W-1:0]   chain_idx [NCELLS+1];
  logic [LIM_W-1:0]   chain_rem [NCELLS+1];

  sbba_pkg::tok_ctl_t res_ctl_q;
  logic [IDX_W-1:0]   res_idx_q;

  logic                          in_beat;
  logic                          div_start, div_busy;
  logic [IDX_W-1:0]              div_quot;
  logic [sbba_pkg::DCOUNT_W-1:0] div_rem;
  logic                          out_load;

  logic                            m_valid_q;
  logic [sbba_pkg::STATUS_W-1:0]   out_status_d, out_status_q;
  logic [23:0]                     out_data_d, out_data_q;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= sbba_pkg::RESET_MODE;
      num_disks_q   <= sbba_pkg::RESET_NUM_DISKS;
      block_count_q <= sbba_pkg::RESET_BLOCK_COUNT;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        sbba_pkg::REG_MODE:        mode_q        <= pwdata[sbba_pkg::MODE_W-1:0];
        sbba_pkg::REG_NUM_DISKS:   num_disks_q   <= pwdata[sbba_pkg::DCOUNT_W-1:0];
        sbba_pkg::REG_BLOCK_COUNT: block_count_q <= pwdata[sbba_pkg::BCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      sbba_pkg::REG_MODE:        prdata = 32'(mode_q);
      sbba_pkg::REG_NUM_DISKS:   prdata = 32'(num_disks_q);
      sbba_pkg::REG_BLOCK_COUNT: prdata = 32'(block_count_q);
      default:                   prdata = '0;
    endcase
  end

  // Effective disk count and search limit, both clamped to the supported range.
  always_comb begin
    eff_disks = num_disks_q;
    if (num_disks_q < sbba_pkg::DCOUNT_W'(sbba_pkg::MIN_DISKS)) begin
      eff_disks = sbba_pkg::DCOUNT_W'(sbba_pkg::MIN_DISKS);
    end else if (num_disks_q > sbba_pkg::DCOUNT_W'(sbba_pkg::MAX_DISKS)) begin
      eff_disks = sbba_pkg::DCOUNT_W'(sbba_pkg::MAX_DISKS);
    end
    bc_ext = CMP_W'(block_count_q);
    limit  = (bc_ext > CMP_W'(MAX_BLOCKS)) ? LIM_W'(MAX_BLOCKS) : LIM_W'(bc_ext);
  end

  // A new request enters the head of the chain on its input beat.
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  assign chain_ctl[0] = '{
    valid:  in_beat,
    action: s_axis_tuser,
    in_map: CMP_W'(s_axis_tdata[sbba_pkg::BLOCK_W-1:0]) < CMP_W'(MAX_BLOCKS),
    done:   1'b0,
    used:   1'b0
  };
  assign chain_idx[0] = IDX_W'(s_axis_tdata[sbba_pkg::BLOCK_W-1:0]);
  assign chain_rem[0] = limit;

  for (genvar c = 0; c < NCELLS; c++) begin : g_cell
    sbba_cell #(
      .CELL_ID (c),
      .WORD_W  (WORD_W),
      .WSEL_W  (WSEL_W),
      .IDX_W   (IDX_W),
      .LIM_W   (LIM_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (chain_ctl[c]),
      .idx_i  (chain_idx[c]),
      .rem_i  (chain_rem[c]),
      .ctl_o  (chain_ctl[c+1]),
      .idx_o  (chain_idx[c+1]),
      .rem_o  (chain_rem[c+1])
    );
  end

  assign div_start = (state_q == S_CHAIN) && chain_ctl[NCELLS].valid;

  sbba_div #(
    .DIVIDEND_W (IDX_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (chain_idx[NCELLS]),
    .divisor_i  (eff_disks),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      res_ctl_q <= chain_ctl[NCELLS];
      res_idx_q <= chain_idx[NCELLS];
    end
  end

  assign out_load = (state_q == S_DIV) && !div_busy && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_beat) state_d = S_CHAIN;
      S_CHAIN: if (div_start) state_d = S_DIV;
      S_DIV:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Result assembly; a failed allocation reports zeros in every data field and status NOSPACE.
  always_comb begin
    logic [DISK_SEL_W-1:0] disk;
    logic [sbba_pkg::BLOCK_W-1:0] local_blk;
    disk      = '0;
    local_blk = res_idx_q[sbba_pkg::BLOCK_W-1:0];
    if (mode_q == sbba_pkg::RAID_STRIPED) begin
      disk      = div_rem[DISK_SEL_W-1:0];
      local_blk = div_quot[sbba_pkg::BLOCK_W-1:0];
    end
    if (res_ctl_q.action == sbba_pkg::ACT_ALLOC) begin
      out_status_d = res_ctl_q.done ? sbba_pkg::ST_OK : sbba_pkg::ST_NOSPACE;
    end else if (res_ctl_q.action == sbba_pkg::ACT_FREE) begin
      out_status_d = sbba_pkg::ST_OK;
    end else begin
      out_status_d = res_ctl_q.used ? sbba_pkg::ST_OK : sbba_pkg::ST_NOTUSED;
    end
    out_data_d = {local_blk, disk, res_ctl_q.used, res_idx_q[sbba_pkg::BLOCK_W-1:0]};
    if (res_ctl_q.action == sbba_pkg::ACT_ALLOC && !res_ctl_q.done) begin
      out_data_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= out_status_d;
      out_data_q   <= out_data_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_status_q;

endmodule

@@ rtl/core/sbba_cell.sv @@
// One cell of the chain: holds one word of the used map and serves the passing token.
module sbba_cell #(
  parameter int CELL_ID = 0,
  parameter int WORD_W  = 32,
  parameter int WSEL_W  = 5,
  parameter int IDX_W   = 10,
  parameter int LIM_W   = 11
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sbba_pkg::tok_ctl_t  ctl_i,
  input  logic [IDX_W-1:0]    idx_i,
  input  logic [LIM_W-1:0]    rem_i,
  output sbba_pkg::tok_ctl_t  ctl_o,
  output logic [IDX_W-1:0]    idx_o,
  output logic [LIM_W-1:0]    rem_o
);

  logic [WORD_W-1:0] word_q, word_d;
  logic [WORD_W-1:0] mask, free_bits;
  logic [WSEL_W-1:0] pos;
  logic              hit;
  sbba_pkg::tok_ctl_t ctl_q, ctl_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [LIM_W-1:0]  rem_q, rem_d;

  always_comb begin
    // Only bits below the remaining block count may be allocated here.
    for (int j = 0; j < WORD_W; j++) begin
      mask[j] = rem_i > LIM_W'(j);
    end
    free_bits = ~word_q & mask;
    pos = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (free_bits[j]) begin
        pos = WSEL_W'(j);
      end
    end
    hit = ctl_i.in_map && ((idx_i >> WSEL_W) == IDX_W'(CELL_ID));

    word_d = word_q;
    ctl_d  = ctl_i;
    idx_d  = idx_i;
    if (ctl_i.valid && !ctl_i.done) begin
      unique case (ctl_i.action)
        sbba_pkg::ACT_ALLOC: begin
          if (|free_bits) begin
            word_d[pos] = 1'b1;
            ctl_d.done  = 1'b1;
            ctl_d.used  = 1'b1;
            idx_d       = IDX_W'(CELL_ID * WORD_W) + IDX_W'(pos);
          end
        end
        sbba_pkg::ACT_FREE: begin
          if (hit) begin
            word_d[idx_i[WSEL_W-1:0]] = 1'b0;
            ctl_d.done = 1'b1;
            ctl_d.used = 1'b0;
          end
        end
        default: begin
          if (hit) begin
            ctl_d.done = 1'b1;
            ctl_d.used = word_q[idx_i[WSEL_W-1:0]];
          end
        end
      endcase
    end
    rem_d = (rem_i > LIM_W'(WORD_W)) ? rem_i - LIM_W'(WORD_W) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
      ctl_q  <= '0;
    end else begin
      word_q <= word_d;
      ctl_q  <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    rem_q <= rem_d;
  end

  assign ctl_o = ctl_q;
  assign idx_o = idx_q;
  assign rem_o = rem_q;

endmodule

@@ rtl/core/sbba_div.sv @@
// Division of a block index by the disk count: reciprocal multiply, then back-multiply.
module sbba_div #(
  parameter int DIVIDEND_W = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [DIVIDEND_W-1:0]         dividend_i,
  input  logic [sbba_pkg::DCOUNT_W-1:0] divisor_i,
  output logic                          busy_o,
  output logic [DIVIDEND_W-1:0]         quot_o,
  output logic [sbba_pkg::DCOUNT_W-1:0] rem_o
);

  // With the reciprocal rounded up and DCOUNT_W extra fraction bits the quotient is exact
  // for every dividend of DIVIDEND_W bits and every nonzero divisor that fits DCOUNT_W bits.
  localparam int SHIFT_W = DIVIDEND_W + sbba_pkg::DCOUNT_W;
  localparam int RECIP_W = SHIFT_W + 1;
  localparam int PROD_W  = DIVIDEND_W + RECIP_W;
  localparam int NDIV    = 2 ** sbba_pkg::DCOUNT_W;

  logic                          busy_q, busy_d;
  logic                          step_q, step_d;
  logic [DIVIDEND_W-1:0]         num_q, num_d;
  logic [sbba_pkg::DCOUNT_W-1:0] div_q, div_d;
  logic [DIVIDEND_W-1:0]         quot_q, quot_d;
  logic [sbba_pkg::DCOUNT_W-1:0] rem_q, rem_d;
  logic [RECIP_W-1:0]            recip;
  logic [PROD_W-1:0]             prod;
  logic [DIVIDEND_W-1:0]         back;

  always_comb begin
    // Reciprocal table; every entry is a constant.
    recip = '0;
    for (int k = 1; k < NDIV; k++) begin
      if (div_q == sbba_pkg::DCOUNT_W'(k)) begin
        recip = RECIP_W'(((64'd1 << SHIFT_W) + 64'(k) - 64'd1) / 64'(k));
      end
    end
    prod = PROD_W'(num_q) * PROD_W'(recip);
    back = quot_q * DIVIDEND_W'(div_q);

    busy_d = busy_q;
    step_d = step_q;
    num_d  = num_q;
    div_d  = div_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = 1'b0;
      num_d  = dividend_i;
      div_d  = divisor_i;
    end else if (busy_q) begin
      if (!step_q) begin
        quot_d = prod[SHIFT_W +: DIVIDEND_W];
        step_d = 1'b1;
      end else begin
        rem_d  = sbba_pkg::DCOUNT_W'(num_q - back);
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    div_q  <= div_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule
